// File: sv/iorej_pkg.sv
// ----------------------------------------------------------------------------
// iorej_pkg: shared constants and types for iterative outlier rejection
// sizes of the sample store and the write transaction into it
// ----------------------------------------------------------------------------
package iorej_pkg;

	// store depth and sample width
	localparam int DEPTH       = 16;
	localparam int SAMPLE_BITS = 24;
	localparam int AW          = $clog2(DEPTH);
	localparam int CW          = $clog2(DEPTH + 1);

	// write transaction into the sample store
	typedef struct packed {
		logic                          en;
		logic [AW-1:0]                 addr;
		logic signed [SAMPLE_BITS-1:0] data;
	} store_wr_t;

endpackage

// File: sv/iorej_store.sv
// ----------------------------------------------------------------------------
// iorej_store: sample store
// one write port, one registered read port
// ----------------------------------------------------------------------------
module iorej_store (
	input  logic                                   clk,
	input  iorej_pkg::store_wr_t                   wr,
	input  logic [iorej_pkg::AW-1:0]               rd_addr,
	output logic signed [iorej_pkg::SAMPLE_BITS-1:0] rd_data
);

	logic signed [iorej_pkg::SAMPLE_BITS-1:0] mem_q [iorej_pkg::DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: sv/iterative_outlier_rejection.sv
// ----------------------------------------------------------------------------
// iterative_outlier_rejection: batch sigma clipping
// stores a batch of samples, repeats rejection passes on last, then streams
// the surviving samples out in arrival order
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tdata: sample[23:0]; tlast: end of batch
//  m_axis   | out       | tdata: kept_sample, kept_count, pass_count, overflow
//                       |        tlast: final_res
//  cfg      | in        | index 0: clip_multiplier[3:0], index 1: repeat_rule
//
// a sample that is not last is written to the store while there is room, and input stays ready
// a last sample runs passes of 3 to 4 walks over the store; one square unit and
// one scaling multiplier serve every step of a pass
// emission walks the store once and waits on m_axis_tready; input is not
// ready until the emission walk has ended
// reset clears the control state; clip_multiplier comes up as 2, repeat_rule 1
// ----------------------------------------------------------------------------
module iterative_outlier_rejection (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // sample[23:0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// kept_sample[23:0], kept_count[28:24], pass_count[33:29], overflow[34]
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);

	localparam int SW   = iorej_pkg::SAMPLE_BITS;
	localparam int AW   = iorej_pkg::AW;
	localparam int CW   = iorej_pkg::CW;
	localparam int DN   = iorej_pkg::DEPTH;
	localparam int SUMW = SW + CW;
	localparam int DW   = SW + CW;
	localparam int SQW  = 2 * DW;
	localparam int TW   = SQW + CW;
	localparam int PW   = TW + 8;
	localparam int NXW  = SW + CW + 1;
	localparam int DFW  = NXW + 1;

	localparam logic [0:0] REG_CLIP = 1'b0;
	localparam logic [0:0] REG_RULE = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_PASS, S_SUM, S_DEV, S_KT, S_T9, S_DROP, S_DECIDE,
		S_R0A, S_R0B, S_R0C, S_SUM2, S_R1A, S_R1B, S_KEPT, S_EMIT
	} state_t;

	state_t                 state_q;
	logic [2:0]             sub_q;
	logic [AW-1:0]          idx_q;
	logic [CW-1:0]          cnt_q;
	logic [DN-1:0]          mask_q;
	logic [DN-1:0]          drop_q;
	logic                   ovf_q;
	logic [4:0]             pass_q;
	logic [CW-1:0]          n_q;
	logic signed [SUMW-1:0] sum_q;
	logic [CW-1:0]          n2_q;
	logic signed [SUMW-1:0] sum2_q;
	logic [DW-1:0]          d_q;
	logic [DW-1:0]          dmax_q;
	logic [SQW-1:0]         sq_q;
	logic [TW-1:0]          tot_q;
	logic [PW-1:0]          kt_q;
	logic [PW-1:0]          t9_q;
	logic [PW-1:0]          prod_q;
	logic [CW-1:0]          kept_q;
	logic [CW-1:0]          emit_q;
	logic [3:0]             clip_q;
	logic                   rule_q;
	logic                   out_v_q;
	logic [SW-1:0]          out_smp_q;
	logic                   out_fin_q;
	logic [4:0]             out_kept_q;
	logic [4:0]             out_pass_q;
	logic                   out_ovf_q;

	iorej_pkg::store_wr_t     wr;
	logic signed [SW-1:0]     rdata;

	// sample store
	iorej_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (idx_q),
		.rd_data (rdata)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign wr.en   = s_axis_tvalid && s_axis_tready && (cnt_q < CW'(DN));
	assign wr.addr = cnt_q[AW-1:0];
	assign wr.data = s_axis_tdata[SW-1:0];

	// distance of the current sample from the mean, scaled by the survivor count n
	logic signed [NXW-1:0] nx;
	logic signed [DFW-1:0] diff;
	logic [DFW-1:0]        dabs;
	logic [DW-1:0]         d_new;
	assign nx    = $signed({1'b0, n_q}) * rdata;
	assign diff  = DFW'(nx) - DFW'(sum_q);
	assign dabs  = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
	assign d_new = dabs[DW-1:0];

	// shared square unit
	logic [DW-1:0]  sq_in;
	logic [SQW-1:0] sq_p;
	assign sq_in = (state_q == S_R0A) ? dmax_q : d_q;
	assign sq_p  = sq_in * sq_in;

	// shared scaling multiplier
	logic [TW-1:0] sc_a;
	logic [7:0]    sc_b;
	logic [PW-1:0] sc_p;
	always_comb begin
		case (state_q)
			S_KT: begin
				sc_a = tot_q;
				sc_b = 8'(clip_q) * 8'(clip_q);
			end
			S_T9: begin
				sc_a = tot_q;
				sc_b = 8'd9;
			end
			S_R1A: begin
				sc_a = TW'(dmax_q);
				sc_b = 8'(n2_q);
			end
			default: begin
				sc_a = TW'(sq_q);
				sc_b = 8'(n_q);
			end
		endcase
	end
	assign sc_p = sc_a * sc_b;

	// exact tests
	logic          rel_ok;
	logic [DW+9:0] d1000;
	assign d1000  = (DW + 10)'(d_q) * (DW + 10)'(1000);
	assign rel_ok = !sum_q[SUMW-1] && (d1000 > (DW + 10)'(unsigned'(sum_q)));

	logic [PW+6:0]     lhs1;
	logic [SUMW+CW-1:0] rhs1;
	logic              rep1;
	assign lhs1 = (PW + 7)'(prod_q) * (PW + 7)'(100);
	assign rhs1 = (SUMW + CW)'(n_q) * (SUMW + CW)'(unsigned'(sum2_q));
	assign rep1 = !sum2_q[SUMW-1] && (lhs1 > (PW + 7)'(rhs1));

	// survivor count
	logic [CW-1:0] pop;
	always_comb begin
		pop = '0;
		for (int i = 0; i < DN; i++) begin
			pop = pop + CW'(mask_q[i]);
		end
	end

	logic walk_end;
	assign walk_end = ({1'b0, idx_q} == (cnt_q - CW'(1)));

	// a surviving sample moves into the output register this cycle
	logic emit_load;
	assign emit_load = (state_q == S_EMIT) && (sub_q != 3'd0) && mask_q[idx_q] &&
		(!out_v_q || m_axis_tready);

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sub_q   <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			mask_q  <= '0;
			drop_q  <= '0;
			ovf_q   <= 1'b0;
			pass_q  <= '0;
			n_q     <= '0;
			n2_q    <= '0;
			kept_q  <= '0;
			emit_q  <= '0;
			clip_q  <= 4'd2;
			rule_q  <= 1'b1;
			out_v_q <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					REG_CLIP: clip_q <= cfg_data;
					REG_RULE: rule_q <= cfg_data[0];
					default:  ;
				endcase
			end
			if (out_v_q && m_axis_tready && !emit_load) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						if (cnt_q < CW'(DN)) begin
							mask_q[cnt_q[AW-1:0]] <= 1'b1;
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							pass_q  <= '0;
							state_q <= S_PASS;
						end
					end
				end
				S_PASS: begin
					pass_q  <= pass_q + 5'd1;
					idx_q   <= '0;
					sub_q   <= '0;
					n_q     <= '0;
					sum_q   <= '0;
					tot_q   <= '0;
					dmax_q  <= '0;
					drop_q  <= '0;
					state_q <= S_SUM;
				end
				S_SUM, S_SUM2: begin
					if (sub_q == 3'd0) begin
						sub_q <= 3'd1;
					end else begin
						if (mask_q[idx_q]) begin
							if (state_q == S_SUM) begin
								n_q   <= n_q + CW'(1);
								sum_q <= sum_q + SUMW'(rdata);
							end else begin
								n2_q   <= n2_q + CW'(1);
								sum2_q <= sum2_q + SUMW'(rdata);
							end
						end
						sub_q <= 3'd0;
						idx_q <= walk_end ? '0 : idx_q + AW'(1);
						if (walk_end) begin
							if (state_q == S_SUM2) begin
								state_q <= S_R1A;
							end else if (n_q == '0 && !mask_q[idx_q]) begin
								state_q <= S_KEPT;
							end else begin
								state_q <= S_DEV;
							end
						end
					end
				end
				S_DEV, S_DROP: begin
					case (sub_q)
						3'd0: sub_q <= 3'd1;
						3'd1: begin
							d_q   <= d_new;
							sub_q <= mask_q[idx_q] ? 3'd2 : 3'd5;
						end
						3'd2: begin
							sq_q  <= sq_p;
							sub_q <= (state_q == S_DEV) ? 3'd4 : 3'd3;
						end
						3'd3: begin
							prod_q <= sc_p;
							sub_q  <= 3'd4;
						end
						default: begin
							if (sub_q == 3'd4) begin
								if (state_q == S_DEV) begin
									tot_q <= tot_q + TW'(sq_q);
									if (d_q > dmax_q) begin
										dmax_q <= d_q;
									end
								end else if (prod_q > kt_q && rel_ok) begin
									drop_q[idx_q] <= 1'b1;
								end
							end
							sub_q <= 3'd0;
							idx_q <= walk_end ? '0 : idx_q + AW'(1);
							if (walk_end) begin
								state_q <= (state_q == S_DEV) ? S_KT : S_DECIDE;
							end
						end
					endcase
				end
				S_KT: begin
					kt_q    <= sc_p;
					state_q <= S_T9;
				end
				S_T9: begin
					t9_q    <= sc_p;
					state_q <= S_DROP;
				end
				S_DECIDE: begin
					if (drop_q == '0) begin
						state_q <= S_KEPT;
					end else begin
						mask_q <= mask_q & ~drop_q;
						if (!rule_q) begin
							state_q <= S_R0A;
						end else begin
							n2_q    <= '0;
							sum2_q  <= '0;
							sub_q   <= '0;
							idx_q   <= '0;
							state_q <= S_SUM2;
						end
					end
				end
				S_R0A: begin
					sq_q    <= sq_p;
					state_q <= S_R0B;
				end
				S_R0B: begin
					prod_q  <= sc_p;
					state_q <= S_R0C;
				end
				S_R0C: begin
					state_q <= (prod_q > t9_q) ? S_PASS : S_KEPT;
				end
				S_R1A: begin
					prod_q  <= sc_p;
					state_q <= S_R1B;
				end
				S_R1B: begin
					state_q <= rep1 ? S_PASS : S_KEPT;
				end
				S_KEPT: begin
					kept_q  <= pop;
					emit_q  <= '0;
					idx_q   <= '0;
					sub_q   <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (sub_q == 3'd0) begin
						sub_q <= 3'd1;
					end else if (!mask_q[idx_q] || !out_v_q || m_axis_tready) begin
						// one output transaction per surviving sample
						if (mask_q[idx_q]) begin
							out_v_q    <= 1'b1;
							out_smp_q  <= rdata;
							out_fin_q  <= (emit_q + CW'(1) == kept_q);
							out_kept_q <= 5'(kept_q);
							out_pass_q <= pass_q;
							out_ovf_q  <= ovf_q;
							emit_q     <= emit_q + CW'(1);
						end
						sub_q <= 3'd0;
						idx_q <= walk_end ? '0 : idx_q + AW'(1);
						if (walk_end) begin
							cnt_q   <= '0;
							mask_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast  = out_fin_q;
	assign m_axis_tdata  = {5'd0, out_ovf_q, out_pass_q, out_kept_q, out_smp_q};

endmodule
